// ----- hdl/awvn_pkg.sv -----
// Shared types, widths and helpers for the area weighted vertex normal block.
// No dependencies; used by awvn_norm and area_weighted_vertex_normals.
package awvn_pkg;

   localparam int MaxVertices = 1024;
   localparam int IdxW   = 10;
   localparam int CoordW = 16;
   localparam int EdgeW  = 17;
   localparam int ProdW  = 34;
   localparam int CrossW = 35;
   localparam int MagW   = 41;
   localparam int LenW   = 42;
   localparam int SqW    = 84;
   localparam int RemW   = 45;
   localparam int NumW   = 57;
   localparam int QuoW   = 15;
   localparam int AccW   = 64;
   localparam int UnitW  = 16;
   localparam int AreaW  = 32;
   localparam int FracW  = 14;
   localparam int VtxW   = 3 * CoordW;
   localparam int AccRowW = 3 * AccW;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_FACE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   localparam logic [0:0] REG_NORMALS_GIVEN = 1'b0;

   typedef logic [MagW-1:0]  mag_type;
   typedef logic [UnitW-1:0] unit_type;

   typedef struct packed {
      logic             start;
      mag_type [2:0]    mag;
      logic    [2:0]    neg;
   } norm_req_type;

   typedef struct packed {
      logic             done;
      unit_type [2:0]   unit;
      logic [LenW-1:0]  len;
   } norm_rsp_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SQ, N_SQRT, N_DIVSET, N_DIV, N_DONE
   } norm_state_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDA, ST_RDB, ST_RDC, ST_EDGE, ST_MUL, ST_NSTART, ST_NWAIT,
      ST_ACRD, ST_ACWR, ST_VRD, ST_VMAG, ST_VSHIFT, ST_OUT
   } top_state_type;

   // Signed add of a cross product component into an accumulator, clamped.
   function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                                input logic [CrossW-1:0] b);
      logic [AccW:0] s;
      s = {a[AccW-1], a} + {{(AccW+1-CrossW){b[CrossW-1]}}, b};
      if (s[AccW] != s[AccW-1])
         sat_add = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      else
         sat_add = s[AccW-1:0];
   endfunction

endpackage

// ----- hdl/awvn_norm.sv -----
// Bit-serial vector normalizer: sum of squares, square root, three divisions.
// Depends on awvn_pkg.
module awvn_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  awvn_pkg::norm_req_type nreq,
   output awvn_pkg::norm_rsp_type nrsp
);

   awvn_pkg::norm_state_type state_ff, state_in;
   awvn_pkg::mag_type [2:0]  mag_ff, mag_in;
   logic [2:0]               neg_ff, neg_in;
   logic [1:0]               comp_ff, comp_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic [awvn_pkg::SqW-1:0]  sq_ff, sq_in, mq_ff, mq_in;
   logic [awvn_pkg::MagW-1:0] mb_ff, mb_in;
   logic [awvn_pkg::LenW-1:0] root_ff, root_in;
   logic [awvn_pkg::RemW-1:0] rem_ff, rem_in;
   logic [awvn_pkg::QuoW-1:0] q_ff, q_in;
   logic [awvn_pkg::NumW-1:0] drem_ff, drem_in, dd_ff, dd_in;
   awvn_pkg::unit_type [2:0] unit_ff, unit_in;

   logic [awvn_pkg::RemW-1:0] rem_sh, trial;
   logic [awvn_pkg::QuoW-1:0] q_nx;
   logic [1:0]                comp_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= awvn_pkg::N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      comp_ff <= comp_in;
      cnt_ff  <= cnt_in;
      sq_ff   <= sq_in;
      mq_ff   <= mq_in;
      mb_ff   <= mb_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      drem_ff <= drem_in;
      dd_ff   <= dd_in;
      unit_ff <= unit_in;
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      comp_in  = comp_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      mq_in    = mq_ff;
      mb_in    = mb_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      drem_in  = drem_ff;
      dd_in    = dd_ff;
      unit_in  = unit_ff;
      comp_nx  = 2'(comp_ff + 2'd1);
      rem_sh   = {rem_ff[awvn_pkg::RemW-3:0], sq_ff[awvn_pkg::SqW-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      q_nx     = {q_ff[awvn_pkg::QuoW-2:0], (drem_ff >= dd_ff)};
      nrsp.done = 1'b0;
      nrsp.unit = unit_ff;
      nrsp.len  = root_ff;

      unique case (state_ff)
         awvn_pkg::N_IDLE: begin
            if (nreq.start) begin
               mag_in  = nreq.mag;
               neg_in  = nreq.neg;
               sq_in   = '0;
               comp_in = '0;
               cnt_in  = '0;
               mq_in   = awvn_pkg::SqW'(nreq.mag[0]);
               mb_in   = nreq.mag[0];
               state_in = awvn_pkg::N_SQ;
            end
         end
         awvn_pkg::N_SQ: begin
            // shift-add square, one multiplier bit per cycle
            if (mb_ff[0]) sq_in = sq_ff + mq_ff;
            mq_in = {mq_ff[awvn_pkg::SqW-2:0], 1'b0};
            mb_in = mb_ff >> 1;
            if (cnt_ff == 6'(awvn_pkg::MagW - 1)) begin
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  root_in  = '0;
                  rem_in   = '0;
                  state_in = awvn_pkg::N_SQRT;
               end else begin
                  comp_in = comp_nx;
                  mq_in   = awvn_pkg::SqW'(mag_ff[comp_nx]);
                  mb_in   = mag_ff[comp_nx];
               end
            end else begin
               cnt_in = 6'(cnt_ff + 6'd1);
            end
         end
         awvn_pkg::N_SQRT: begin
            // restoring square root, two radicand bits per step
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[awvn_pkg::LenW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[awvn_pkg::LenW-2:0], 1'b0};
            end
            sq_in = {sq_ff[awvn_pkg::SqW-3:0], 2'b00};
            if (cnt_ff == 6'(awvn_pkg::LenW - 1)) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = awvn_pkg::N_DIVSET;
            end else begin
               cnt_in = 6'(cnt_ff + 6'd1);
            end
         end
         awvn_pkg::N_DIVSET: begin
            if (root_ff == '0) begin
               unit_in  = '0;
               state_in = awvn_pkg::N_DONE;
            end else begin
               // numerator mag*2^14 + len/2, rounds to nearest
               drem_in = awvn_pkg::NumW'({mag_ff[comp_ff], awvn_pkg::FracW'(0)})
                         + awvn_pkg::NumW'(root_ff >> 1);
               dd_in   = awvn_pkg::NumW'({root_ff, awvn_pkg::FracW'(0)});
               q_in    = '0;
               cnt_in  = '0;
               state_in = awvn_pkg::N_DIV;
            end
         end
         awvn_pkg::N_DIV: begin
            if (drem_ff >= dd_ff) drem_in = drem_ff - dd_ff;
            q_in  = q_nx;
            dd_in = dd_ff >> 1;
            if (cnt_ff == 6'(awvn_pkg::QuoW - 1)) begin
               unit_in[comp_ff] = neg_ff[comp_ff] ? 16'(-{1'b0, q_nx}) : 16'({1'b0, q_nx});
               if (comp_ff == 2'd2) begin
                  state_in = awvn_pkg::N_DONE;
               end else begin
                  comp_in  = comp_nx;
                  state_in = awvn_pkg::N_DIVSET;
               end
            end else begin
               cnt_in = 6'(cnt_ff + 6'd1);
            end
         end
         awvn_pkg::N_DONE: begin
            nrsp.done = 1'b1;
            state_in  = awvn_pkg::N_IDLE;
         end
         default: state_in = awvn_pkg::N_IDLE;
      endcase
   end

endmodule

// ----- hdl/area_weighted_vertex_normals.sv -----
// Top level: vertex store, normal accumulators, cross product, sequencer.
// Depends on awvn_pkg and awvn_norm.
//
// channel   dir   handshake              payload
// req_      in    tvalid/tready          tuser command, tdata indices+coords
// rsp_      out   tvalid/tready          tuser kind+degenerate, tdata units+area
// csr_      in    psel/penable/pwrite    normals_given at address 0
//
// Load and clear write their memory straight from idle. A face reads its
// three vertices, then accumulates unless normals are given; a vertex read
// adds up to 24 accumulator right shifts. The bit-serial squarer (3 x 41 bits),
// the 42-bit square root and three 15-bit divisions in awvn_norm dominate.
// One word is worked on at a time; req_tready is high only when idle.
// A finished word waits in the rsp_ register; the block may go idle and take
// the next word meanwhile. Reset clears control state only; memories are
// not cleared, so entries must be loaded or cleared before use.
module area_weighted_vertex_normals (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // index_a, index_b, index_c, coord_x/y/z, 2'b0
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // unit_x, unit_y, unit_z, face_area
   output logic [1:0]  rsp_tuser,  // result_kind, degenerate
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = awvn_pkg::IdxW;

   awvn_pkg::top_state_type state_ff, state_in;
   logic              ng_ff, ng_in;
   logic [IW-1:0]     ia_ff, ia_in, ib_ff, ib_in, ic_ff, ic_in;
   logic              kind_ff, kind_in;
   logic [awvn_pkg::VtxW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [awvn_pkg::EdgeW-1:0]  e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [awvn_pkg::ProdW-1:0]  prod_ff, prod_in;
   logic signed [awvn_pkg::CrossW-1:0] cx_ff [3], cx_in [3];
   logic [2:0]        step_ff, step_in;
   logic [1:0]        j_ff, j_in;
   logic [awvn_pkg::AccW-1:0] vm_ff [3], vm_in [3];
   logic [2:0]        vneg_ff, vneg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [79:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;

   // memories
   logic [awvn_pkg::VtxW-1:0]   vert_mem [awvn_pkg::MaxVertices];
   logic [awvn_pkg::VtxW-1:0]   vert_q_ff, vert_wdata;
   logic [IW-1:0]               vert_raddr, vert_waddr;
   logic                        vert_we;
   logic [awvn_pkg::AccRowW-1:0] acc_mem [awvn_pkg::MaxVertices];
   logic [awvn_pkg::AccRowW-1:0] acc_q_ff, acc_wdata;
   logic [IW-1:0]               acc_raddr, acc_waddr;
   logic                        acc_we;

   awvn_pkg::norm_req_type nreq;
   awvn_pkg::norm_rsp_type nrsp;

   logic              req_fire, out_load, csr_wr;
   awvn_pkg::cmd_type cmd;
   logic [IW-1:0]     idx_j;
   logic signed [awvn_pkg::EdgeW-1:0] ma, mb;
   logic [awvn_pkg::AccW-1:0] acc_word [3];
   logic [awvn_pkg::AreaW-1:0] area;

   awvn_norm u_norm (
      .clock (clock),
      .reset (reset),
      .nreq  (nreq),
      .nrsp  (nrsp)
   );

   always_ff @(posedge clock) begin
      if (vert_we) vert_mem[vert_waddr] <= vert_wdata;
      vert_q_ff <= vert_mem[vert_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      acc_q_ff <= acc_mem[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awvn_pkg::ST_IDLE;
         ng_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ng_ff        <= ng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ia_ff   <= ia_in;
      ib_ff   <= ib_in;
      ic_ff   <= ic_in;
      kind_ff <= kind_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      prod_ff <= prod_in;
      cx_ff   <= cx_in;
      step_ff <= step_in;
      j_ff    <= j_in;
      vm_ff   <= vm_in;
      vneg_ff <= vneg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign ng_in      = (csr_wr && csr_paddr == {awvn_pkg::REG_NORMALS_GIVEN, 2'b00})
                       ? csr_pwdata[0] : ng_ff;
   assign csr_prdata = {31'b0, ng_ff};

   assign req_tready = (state_ff == awvn_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign cmd        = awvn_pkg::cmd_type'(req_tuser);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign area = (|nrsp.len[awvn_pkg::LenW-1:awvn_pkg::AreaW]) ? '1
                 : nrsp.len[awvn_pkg::AreaW-1:0];

   always_comb begin
      unique case (j_ff)
         2'd0:    idx_j = ia_ff;
         2'd1:    idx_j = ib_ff;
         default: idx_j = ic_ff;
      endcase
      // cross product terms, one product per step
      unique case (step_ff)
         3'd0:    begin ma = e1_ff[1]; mb = e2_ff[2]; end
         3'd1:    begin ma = e1_ff[2]; mb = e2_ff[1]; end
         3'd2:    begin ma = e1_ff[2]; mb = e2_ff[0]; end
         3'd3:    begin ma = e1_ff[0]; mb = e2_ff[2]; end
         3'd4:    begin ma = e1_ff[0]; mb = e2_ff[1]; end
         default: begin ma = e1_ff[1]; mb = e2_ff[0]; end
      endcase
      for (int i = 0; i < 3; i++)
         acc_word[i] = acc_q_ff[i*awvn_pkg::AccW +: awvn_pkg::AccW];
   end

   always_comb begin
      state_in = state_ff;
      ia_in = ia_ff; ib_in = ib_ff; ic_in = ic_ff;
      kind_in = kind_ff;
      pa_in = pa_ff; pb_in = pb_ff;
      e1_in = e1_ff; e2_in = e2_ff;
      prod_in = prod_ff;
      cx_in = cx_ff;
      step_in = step_ff;
      j_in = j_ff;
      vm_in = vm_ff;
      vneg_in = vneg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      vert_we = 1'b0;
      vert_waddr = req_tdata[IW-1:0];
      vert_wdata = req_tdata[30 +: awvn_pkg::VtxW];
      vert_raddr = ia_ff;
      acc_we = 1'b0;
      acc_waddr = req_tdata[IW-1:0];
      acc_wdata = '0;
      acc_raddr = idx_j;
      nreq.start = 1'b0;
      for (int i = 0; i < 3; i++) begin
         nreq.mag[i] = awvn_pkg::MagW'(cx_ff[i] < 0 ? -cx_ff[i] : cx_ff[i]);
         nreq.neg[i] = cx_ff[i] < 0;
      end
      out_load = 1'b0;

      unique case (state_ff)
         awvn_pkg::ST_IDLE: begin
            if (req_fire) begin
               ia_in = req_tdata[IW-1:0];
               ib_in = req_tdata[2*IW-1:IW];
               ic_in = req_tdata[3*IW-1:2*IW];
               unique case (cmd)
                  awvn_pkg::CMD_LOAD:  vert_we = 1'b1;
                  awvn_pkg::CMD_CLEAR: acc_we = 1'b1;
                  awvn_pkg::CMD_FACE: begin
                     kind_in  = awvn_pkg::KIND_FACE;
                     state_in = awvn_pkg::ST_RDA;
                  end
                  awvn_pkg::CMD_READ: begin
                     kind_in  = awvn_pkg::KIND_VERTEX;
                     j_in     = 2'd0;
                     state_in = awvn_pkg::ST_VRD;
                  end
                  default: state_in = awvn_pkg::ST_IDLE;
               endcase
            end
         end
         awvn_pkg::ST_RDA: begin
            vert_raddr = ia_ff;
            state_in = awvn_pkg::ST_RDB;
         end
         awvn_pkg::ST_RDB: begin
            vert_raddr = ib_ff;
            pa_in = vert_q_ff;
            state_in = awvn_pkg::ST_RDC;
         end
         awvn_pkg::ST_RDC: begin
            vert_raddr = ic_ff;
            pb_in = vert_q_ff;
            state_in = awvn_pkg::ST_EDGE;
         end
         awvn_pkg::ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = awvn_pkg::EdgeW'($signed(pb_ff[i*16 +: 16]))
                          - awvn_pkg::EdgeW'($signed(pa_ff[i*16 +: 16]));
               e2_in[i] = awvn_pkg::EdgeW'($signed(vert_q_ff[i*16 +: 16]))
                          - awvn_pkg::EdgeW'($signed(pa_ff[i*16 +: 16]));
               cx_in[i] = '0;
            end
            step_in  = '0;
            state_in = awvn_pkg::ST_MUL;
         end
         awvn_pkg::ST_MUL: begin
            // product of step k is registered, accumulated at step k+1
            prod_in = ma * mb;
            unique case (step_ff)
               3'd1:    cx_in[0] = cx_ff[0] + awvn_pkg::CrossW'(prod_ff);
               3'd2:    cx_in[0] = cx_ff[0] - awvn_pkg::CrossW'(prod_ff);
               3'd3:    cx_in[1] = cx_ff[1] + awvn_pkg::CrossW'(prod_ff);
               3'd4:    cx_in[1] = cx_ff[1] - awvn_pkg::CrossW'(prod_ff);
               3'd5:    cx_in[2] = cx_ff[2] + awvn_pkg::CrossW'(prod_ff);
               3'd6:    cx_in[2] = cx_ff[2] - awvn_pkg::CrossW'(prod_ff);
               default: ;
            endcase
            step_in = 3'(step_ff + 3'd1);
            if (step_ff == 3'd6) state_in = awvn_pkg::ST_NSTART;
         end
         awvn_pkg::ST_NSTART: begin
            nreq.start = 1'b1;
            state_in = awvn_pkg::ST_NWAIT;
         end
         awvn_pkg::ST_NWAIT: begin
            if (nrsp.done) begin
               j_in = 2'd0;
               if (kind_ff == awvn_pkg::KIND_FACE && !ng_ff)
                  state_in = awvn_pkg::ST_ACRD;
               else
                  state_in = awvn_pkg::ST_OUT;
            end
         end
         awvn_pkg::ST_ACRD: begin
            state_in = awvn_pkg::ST_ACWR;
         end
         awvn_pkg::ST_ACWR: begin
            acc_we = 1'b1;
            acc_waddr = idx_j;
            acc_wdata = {awvn_pkg::sat_add(acc_word[2], cx_ff[2]),
                         awvn_pkg::sat_add(acc_word[1], cx_ff[1]),
                         awvn_pkg::sat_add(acc_word[0], cx_ff[0])};
            if (j_ff == 2'd2) begin
               state_in = awvn_pkg::ST_OUT;
            end else begin
               j_in = 2'(j_ff + 2'd1);
               state_in = awvn_pkg::ST_ACRD;
            end
         end
         awvn_pkg::ST_VRD: begin
            state_in = awvn_pkg::ST_VMAG;
         end
         awvn_pkg::ST_VMAG: begin
            for (int i = 0; i < 3; i++) begin
               vneg_in[i] = acc_word[i][awvn_pkg::AccW-1];
               vm_in[i]   = acc_word[i][awvn_pkg::AccW-1] ? -acc_word[i] : acc_word[i];
            end
            state_in = awvn_pkg::ST_VSHIFT;
         end
         awvn_pkg::ST_VSHIFT: begin
            // shift all three right until each is below 2^40
            if (|{vm_ff[0][63:40], vm_ff[1][63:40], vm_ff[2][63:40]}) begin
               for (int i = 0; i < 3; i++) vm_in[i] = vm_ff[i] >> 1;
            end else begin
               nreq.start = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  nreq.mag[i] = vm_ff[i][awvn_pkg::MagW-1:0];
                  nreq.neg[i] = vneg_ff[i];
               end
               state_in = awvn_pkg::ST_NWAIT;
            end
         end
         awvn_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               rsp_data_in = {(kind_ff == awvn_pkg::KIND_FACE) ? area : '0,
                              nrsp.unit[2], nrsp.unit[1], nrsp.unit[0]};
               rsp_user_in = {(nrsp.len == '0), kind_ff};
               state_in = awvn_pkg::ST_IDLE;
            end
         end
         default: state_in = awvn_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_tready);

endmodule
